FILE: design/bmm_pkg.sv
package bmm_pkg;
  localparam int MaxVertices = 32;
  localparam int CountW = 6;
  localparam int RowW = 32;
  localparam int IdxW = 5;
  localparam logic [1:0] AddrLeftCount = 2'd0;
  localparam logic [1:0] AddrRightCount = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;        // write adjacency row
    logic run_start;   // clear partners, root = 0
    logic root_begin;  // push root frame, clear visited
    logic scan;        // scan top frame
    logic root_next;   // advance root
  } bmm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic roots_done;
    logic root_skip;
    logic search_done;
  } bmm_stat_t;
endpackage

FILE: design/bipartite_max_matching.sv
// Maximum bipartite matching, Kuhn augmenting-path search.
// Load request (mode 0): one cycle, next request accepted right after.
// Run request (mode 1): each left vertex is visited in the root state, and a searched vertex
//   then scans step by step (push, pop or path flip), with a closing scan step when its search
//   fails; a final root-state visit raises out_valid. Result held until taken, input stalled.
// Reset (rst, synchronous): counts zero, adjacency reads as zero, idle.
module bipartite_max_matching #(
  parameter int MAX_VERTICES = bmm_pkg::MaxVertices
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       ready,
  input  logic                       mode,
  input  logic [bmm_pkg::IdxW-1:0]   row_index,
  input  logic [bmm_pkg::RowW-1:0]   row_bits,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bmm_pkg::CountW-1:0] match_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bmm_pkg::*;

  logic [CountW-1:0] left_count, right_count;
  bmm_cmd_t cmd;
  bmm_stat_t stat;
  logic in_fire;

  assign pready = 1'b1;
  assign in_fire = valid && ready;

  // register file: word address = paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count <= '0;
      right_count <= '0;
    end else if (psel && penable && pwrite) begin
      if ({1'b0, paddr[2]} == AddrLeftCount) left_count <= pwdata[CountW-1:0];
      if ({1'b0, paddr[2]} == AddrRightCount) right_count <= pwdata[CountW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2]) prdata[CountW-1:0] = right_count;
    else prdata[CountW-1:0] = left_count;
  end

  bmm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .mode, .ready, .out_valid, .out_ready, .cmd, .stat
  );

  bmm_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk, .rst, .cmd, .stat, .row_index, .row_bits, .left_count, .right_count,
    .match_count
  );

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !ready)
    else $error("ready while result pending");
  assert property (@(posedge clk) disable iff (rst) (valid && ready && !mode) |=> ready)
    else $error("load stalled");
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(!ready))
    else $error("result without run");
endmodule

FILE: design/bmm_datapath.sv
module bmm_datapath #(
  parameter int MAX_VERTICES = bmm_pkg::MaxVertices
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmm_pkg::bmm_cmd_t             cmd,
  output bmm_pkg::bmm_stat_t            stat,
  input  logic [bmm_pkg::IdxW-1:0]      row_index,
  input  logic [bmm_pkg::RowW-1:0]      row_bits,
  input  logic [bmm_pkg::CountW-1:0]    left_count,
  input  logic [bmm_pkg::CountW-1:0]    right_count,
  output logic [bmm_pkg::CountW-1:0]    match_count
);
  import bmm_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int NR = (MAX_VERTICES < RowW) ? MAX_VERTICES : RowW;
  localparam int KW = $clog2(NR + 1);

  logic [RowW-1:0] adjacency [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_valid;
  logic [VW-1:0] left_partner [MAX_VERTICES];
  logic [VW-1:0] right_partner [NR];
  logic [MAX_VERTICES-1:0] left_valid;
  logic [NR-1:0] right_valid;
  logic [NR-1:0] visited_mask;
  logic [VW-1:0] stack_left [MAX_VERTICES];
  logic [KW-1:0] stack_hit [MAX_VERTICES];
  logic [DW-1:0] depth;
  logic [DW-1:0] root;
  logic [CountW-1:0] nl, nr;

  // clamp counts
  always_comb begin
    nl = (32'(left_count) > MAX_VERTICES) ? CountW'(MAX_VERTICES) : left_count;
    nr = (32'(right_count) > NR) ? CountW'(NR) : right_count;
  end

  logic [VW-1:0] top_idx;
  logic [VW-1:0] top_u;
  logic [RowW-1:0] top_row;
  logic [NR-1:0] cand;
  logic found;
  logic [KW-1:0] k;
  assign top_idx = VW'(depth - DW'(1));
  assign top_u = stack_left[top_idx];
  assign top_row = adj_valid[top_u] ? adjacency[top_u] : '0;

  always_comb begin
    for (int j = 0; j < NR; j++) cand[j] = top_row[j] && !visited_mask[j] && (j < nr);
    found = 1'b0;
    k = '0;
    for (int j = NR - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found = 1'b1;
        k = KW'(j);
      end
    end
  end

  logic [VW-1:0] kv;
  assign kv = VW'(k);
  logic kfree;
  assign kfree = !right_valid[kv];

  assign stat.roots_done = (root >= DW'(nl));
  assign stat.root_skip = left_valid[VW'(root)];
  assign stat.search_done = (depth == '0) || (found && kfree);

  logic commit;
  assign commit = cmd.scan && depth != '0 && found && kfree;

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_valid <= '0;
      left_valid <= '0;
      right_valid <= '0;
      visited_mask <= '0;
      depth <= '0;
      root <= '0;
      match_count <= '0;
    end else begin
      if (cmd.load && 32'(row_index) < MAX_VERTICES) begin
        adjacency[VW'(row_index)] <= row_bits;
        adj_valid[VW'(row_index)] <= 1'b1;
      end
      if (cmd.run_start) begin
        left_valid <= '0;
        right_valid <= '0;
        root <= '0;
        match_count <= '0;
        depth <= '0;
      end
      if (cmd.root_begin) begin
        stack_left[0] <= VW'(root);
        visited_mask <= '0;
        depth <= DW'(1);
      end
      if (cmd.root_next) root <= root + DW'(1);
      if (cmd.scan && depth != '0) begin
        if (!found) begin
          depth <= depth - DW'(1);
        end else begin
          visited_mask[kv] <= 1'b1;
          stack_hit[top_idx] <= k;
          if (kfree) begin
            // flip the whole augmenting path in one step
            for (int f = 0; f < MAX_VERTICES; f++) begin
              if (DW'(f) < depth - DW'(1)) begin
                right_partner[VW'(stack_hit[f])] <= stack_left[f];
                right_valid[VW'(stack_hit[f])] <= 1'b1;
                left_partner[stack_left[f]] <= VW'(stack_hit[f]);
                left_valid[stack_left[f]] <= 1'b1;
              end
            end
            right_partner[kv] <= top_u;
            right_valid[kv] <= 1'b1;
            left_partner[top_u] <= kv;
            left_valid[top_u] <= 1'b1;
            match_count <= match_count + CountW'(1);
            depth <= '0;
          end else begin
            stack_left[VW'(depth)] <= right_partner[kv];
            depth <= depth + DW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) assert (!(commit && match_count == CountW'(63)))
      else $error("match count overflow");
  end
  assert property (@(posedge clk) disable iff (rst) commit |=> depth == '0)
    else $error("depth not cleared after augment");
  assert property (@(posedge clk) disable iff (rst) 32'(depth) <= MAX_VERTICES)
    else $error("stack overflow");
  assert property (@(posedge clk) disable iff (rst) cmd.run_start |=> root == '0)
    else $error("root not reset");
endmodule

FILE: design/bmm_ctrl.sv
module bmm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               mode,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bmm_pkg::bmm_cmd_t  cmd,
  input  bmm_pkg::bmm_stat_t stat
);
  import bmm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROOT, S_SCAN, S_DONE} state_t;
  state_t state;

  assign ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_fire && !mode;
    cmd.run_start = in_fire && mode;
    cmd.root_begin = (state == S_ROOT) && !stat.roots_done && !stat.root_skip;
    cmd.root_next = (state == S_ROOT) && !stat.roots_done && stat.root_skip
                    || (state == S_SCAN) && stat.search_done;
    cmd.scan = (state == S_SCAN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire && mode) state <= S_ROOT;
        S_ROOT: begin
          if (stat.roots_done) begin
            state <= S_DONE;
            out_valid <= 1'b1;
          end else if (!stat.root_skip) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: if (stat.search_done) state <= S_ROOT;
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_DONE)
    else $error("result shown outside done");
  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
endmodule
